FILE: rtl/rws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rws_pkg
// Shared constants and types for the running and window statistics unit.
// ----------------------------------------------------------------------------
package rws_pkg;

   localparam int WINDOW_DEPTH = 1024;
   localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
   localparam int CFG_W        = 11;
   localparam int SAMPLE_W     = 16;
   localparam int COUNT_W      = 20;
   localparam int MEAN_W       = 32;
   localparam int VAR_W        = 40;
   localparam int SQ_W         = 64;
   localparam int DIVIDEND_W   = 64;
   localparam int DIVISOR_W    = 20;
   localparam int QSTEP_W      = 7;

   localparam logic [CFG_W-1:0]   WINDOW_RESET = CFG_W'(64);
   localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
   localparam logic [MEAN_W-1:0]  MEAN_MAX     = 32'hFFFF_0000;

   typedef struct packed {
      logic start;
      logic short_op;
   } div_req_type;

endpackage

FILE: rtl/rws_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rws_divider
// Radix-2 restoring divider, one quotient bit per cycle. A short transaction
// divides the low 32 bits of the dividend, a long one all 64.
// ----------------------------------------------------------------------------
module rws_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  rws_pkg::div_req_type            div_req,
   input  logic [rws_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [rws_pkg::DIVISOR_W-1:0]   divisor,
   output logic                            done,
   output logic [rws_pkg::DIVIDEND_W-1:0]  quotient
);
   import rws_pkg::*;

   logic [QSTEP_W-1:0]    cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [DIVIDEND_W-1:0] num_ff, num_in;
   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   assign trial = {rem_ff, num_ff[DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      num_in  = num_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         cnt_in  = div_req.short_op ? QSTEP_W'(32) : QSTEP_W'(64);
         num_in  = div_req.short_op ? {dividend[31:0], 32'b0} : dividend;
         quot_in = '0;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - QSTEP_W'(1);
         num_in  = {num_ff[DIVIDEND_W-2:0], 1'b0};
         quot_in = {quot_ff[DIVIDEND_W-2:0], fits};
         rem_in  = fits ? DIVISOR_W'(trial - {1'b0, dsr_ff}) : trial[DIVISOR_W-1:0];
         done_in = (cnt_ff == QSTEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

FILE: rtl/running_and_window_statistics_unit.sv
`timescale 1ns / 1ps
// Divisions: the shared 1-bit-per-cycle divider does all of them (the low 32 dividend bits
//   for the two means, all 64 bits for the two variances); a full window takes all four,
//   fewer are done before the window fills, for the first transaction or a window of one.
//   Response stalls hold a finished transaction in ST_DONE once the output register is occupied.
// Flow: a new request is stalled until the previous transaction leaves ST_DONE; a finished
//   response waits in its output register while the next request is taken.
// Reset: synchronous, clears statistics, window_length to 64; the ring store is not cleared.
// ----------------------------------------------------------------------------
// running_and_window_statistics_unit
// Welford running mean/variance plus sliding-window mean/variance, min, max.
// ----------------------------------------------------------------------------
module running_and_window_statistics_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [rws_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rws_pkg::COUNT_W-1:0]     rsp_sample_total,
   output logic [rws_pkg::MEAN_W-1:0]      rsp_mean_all,
   output logic [rws_pkg::VAR_W-1:0]       rsp_variance_all,
   output logic [rws_pkg::MEAN_W-1:0]      rsp_mean_window,
   output logic [rws_pkg::VAR_W-1:0]       rsp_variance_window,
   output logic [rws_pkg::SAMPLE_W-1:0]    rsp_smallest,
   output logic [rws_pkg::SAMPLE_W-1:0]    rsp_largest,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rws_pkg::CFG_W-1:0]       csr_window_length
);
   import rws_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b0000_0000_0001,
      ST_DIV_MEAN  = 12'b0000_0000_0010,
      ST_MUL_RUN   = 12'b0000_0000_0100,
      ST_ACC_RUN   = 12'b0000_0000_1000,
      ST_DIV_VAR   = 12'b0000_0001_0000,
      ST_WIN_CHK   = 12'b0000_0010_0000,
      ST_DIV_WMEAN = 12'b0000_0100_0000,
      ST_MUL_WX    = 12'b0000_1000_0000,
      ST_MUL_WF    = 12'b0001_0000_0000,
      ST_ACC_WIN   = 12'b0010_0000_0000,
      ST_DIV_WVAR  = 12'b0100_0000_0000,
      ST_DONE      = 12'b1000_0000_0000
   } state_type;

   function automatic logic [SQ_W-1:0] apply_delta(input logic [SQ_W-1:0] acc,
                                                    input logic signed [41:0] d);
      logic [41:0]   m;
      logic [SQ_W:0] s;
      m = '0;
      s = '0;
      if (!d[41]) begin
         s = {1'b0, acc} + (SQ_W+1)'(d);
         return s[SQ_W] ? '1 : s[SQ_W-1:0];
      end
      m = -d;
      return (acc < SQ_W'(m)) ? '0 : acc - SQ_W'(m);
   endfunction

   function automatic logic [VAR_W-1:0] sat_var(input logic [DIVIDEND_W-1:0] q);
      return (q[DIVIDEND_W-1:VAR_W] != '0) ? '1 : q[VAR_W-1:0];
   endfunction

   function automatic logic [31:0] mag34(input logic signed [33:0] v);
      logic [33:0] a;
      a = v[33] ? 34'(-v) : 34'(v);
      return a[31:0];
   endfunction

   state_type state_ff, state_in;

   logic [CFG_W-1:0]      wl_ff, wl_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [MEAN_W-1:0]     run_mean_ff, run_mean_in;
   logic [SQ_W-1:0]       run_sq_ff, run_sq_in;
   logic [MEAN_W-1:0]     sl_mean_ff, sl_mean_in;
   logic [SQ_W-1:0]       sl_sq_ff, sl_sq_in;
   logic [ADDR_W-1:0]     slot_ff, slot_in;
   logic [SAMPLE_W-1:0]   min_ff, min_in;
   logic [SAMPLE_W-1:0]   max_ff, max_in;
   logic [MEAN_W-1:0]     x_ff, x_in;
   logic signed [33:0]    da_ff, da_in;
   logic [MEAN_W-1:0]     so_ff, so_in;
   logic [SAMPLE_W-1:0]   leave_ff;
   logic [63:0]           prod_ff, prod_in;
   logic                  prod_neg_ff, prod_neg_in;
   logic signed [40:0]    tx_ff, tx_in;
   logic [VAR_W-1:0]      var_all_ff, var_all_in;
   logic [VAR_W-1:0]      var_win_ff, var_win_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]    o_total_ff, o_total_in;
   logic [MEAN_W-1:0]     o_mean_ff, o_mean_in;
   logic [VAR_W-1:0]      o_var_ff, o_var_in;
   logic [MEAN_W-1:0]     o_wmean_ff, o_wmean_in;
   logic [VAR_W-1:0]      o_wvar_ff, o_wvar_in;
   logic [SAMPLE_W-1:0]   o_min_ff, o_min_in;
   logic [SAMPLE_W-1:0]   o_max_ff, o_max_in;

   logic [SAMPLE_W-1:0]   mem [WINDOW_DEPTH];

   logic                  req_fire;
   logic [CFG_W-1:0]      w_eff;
   logic [ADDR_W:0]       slot_ext, w_ext, oldest_ext;
   logic [MEAN_W-1:0]     x_new, f_ext;
   logic signed [33:0]    q_signed, mean_new, db, dw, sn_raw;
   logic signed [33:0]    mul_a, mul_b;
   logic [39:0]           term_mag;
   logic signed [40:0]    term;
   logic [MEAN_W-1:0]     sn_clamped;
   logic [COUNT_W-1:0]    count_next;

   div_req_type           div_req;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] div_quot;

   rws_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      if (wl_ff == '0) begin
         w_eff = CFG_W'(1);
      end else if (32'(wl_ff) > WINDOW_DEPTH) begin
         w_eff = CFG_W'(WINDOW_DEPTH);
      end else begin
         w_eff = wl_ff;
      end
   end

   assign slot_ext   = {1'b0, slot_ff};
   assign w_ext      = (ADDR_W+1)'(w_eff);
   assign oldest_ext = (slot_ext >= w_ext) ? slot_ext - w_ext
                                           : slot_ext + (ADDR_W+1)'(WINDOW_DEPTH) - w_ext;

   assign x_new      = {req_sample, 16'b0};
   assign f_ext      = {leave_ff, 16'b0};
   assign count_next = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_W'(1);
   assign dw         = $signed({2'b0, x_ff}) - $signed({2'b0, f_ext});
   assign db         = $signed({2'b0, x_ff}) - $signed({2'b0, run_mean_ff});

   always_comb begin
      logic signed [33:0] qs;
      qs = $signed({2'b0, div_quot[31:0]});
      if (state_ff == ST_DIV_WMEAN) begin
         q_signed = dw[33] ? -qs : qs;
      end else begin
         q_signed = da_ff[33] ? -qs : qs;
      end
   end

   assign mean_new = $signed({2'b0, run_mean_ff}) + q_signed;
   assign sn_raw   = $signed({2'b0, so_ff}) + q_signed;

   always_comb begin
      if (sn_raw < 0) begin
         sn_clamped = '0;
      end else if (sn_raw > $signed({2'b0, MEAN_MAX})) begin
         sn_clamped = MEAN_MAX;
      end else begin
         sn_clamped = sn_raw[31:0];
      end
   end

   always_comb begin
      mul_a = da_ff;
      mul_b = db;
      if (state_ff == ST_MUL_WX) begin
         mul_a = $signed({2'b0, x_ff}) - $signed({2'b0, so_ff});
         mul_b = $signed({2'b0, x_ff}) - $signed({2'b0, sl_mean_ff});
      end else if (state_ff == ST_MUL_WF) begin
         mul_a = $signed({2'b0, f_ext}) - $signed({2'b0, so_ff});
         mul_b = $signed({2'b0, f_ext}) - $signed({2'b0, sl_mean_ff});
      end
   end

   assign term_mag = prod_ff[63:24];
   assign term     = prod_neg_ff ? -$signed({1'b0, term_mag}) : $signed({1'b0, term_mag});

   always_comb begin
      state_in     = state_ff;
      wl_in        = csr_valid ? csr_window_length : wl_ff;
      count_in     = count_ff;
      run_mean_in  = run_mean_ff;
      run_sq_in    = run_sq_ff;
      sl_mean_in   = sl_mean_ff;
      sl_sq_in     = sl_sq_ff;
      slot_in      = slot_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      x_in         = x_ff;
      da_in        = da_ff;
      so_in        = so_ff;
      prod_in      = prod_ff;
      prod_neg_in  = prod_neg_ff;
      tx_in        = tx_ff;
      var_all_in   = var_all_ff;
      var_win_in   = var_win_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      o_total_in   = o_total_ff;
      o_mean_in    = o_mean_ff;
      o_var_in     = o_var_ff;
      o_wmean_in   = o_wmean_ff;
      o_wvar_in    = o_wvar_ff;
      o_min_in     = o_min_ff;
      o_max_in     = o_max_ff;
      div_req      = '{start: 1'b0, short_op: 1'b0};
      div_dividend = '0;
      div_divisor  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               x_in     = x_new;
               da_in    = $signed({2'b0, x_new}) - $signed({2'b0, run_mean_ff});
               count_in = count_next;
               slot_in  = (slot_ff == ADDR_W'(WINDOW_DEPTH - 1)) ? '0
                                                                 : slot_ff + ADDR_W'(1);
               if (req_sample > max_ff) max_in = req_sample;
               if (req_sample < min_ff) min_in = req_sample;
               div_req      = '{start: 1'b1, short_op: 1'b1};
               div_dividend = DIVIDEND_W'(mag34(da_in));
               div_divisor  = count_next;
               state_in     = ST_DIV_MEAN;
            end
         end
         ST_DIV_MEAN: begin
            if (div_done) begin
               run_mean_in = mean_new[31:0];
               state_in    = ST_MUL_RUN;
            end
         end
         ST_MUL_RUN, ST_MUL_WX, ST_MUL_WF: begin
            prod_in     = 64'(mag34(mul_a)) * 64'(mag34(mul_b));
            prod_neg_in = mul_a[33] ^ mul_b[33];
            if (state_ff == ST_MUL_RUN) begin
               state_in = ST_ACC_RUN;
            end else if (state_ff == ST_MUL_WX) begin
               state_in = ST_MUL_WF;
            end else begin
               tx_in    = term;
               state_in = ST_ACC_WIN;
            end
         end
         ST_ACC_RUN: begin
            run_sq_in = apply_delta(run_sq_ff, 42'(term));
            if (count_ff > COUNT_W'(1)) begin
               div_req      = '{start: 1'b1, short_op: 1'b0};
               div_dividend = run_sq_in;
               div_divisor  = count_ff - COUNT_W'(1);
               state_in     = ST_DIV_VAR;
            end else begin
               var_all_in = '0;
               state_in   = ST_WIN_CHK;
            end
         end
         ST_DIV_VAR: begin
            if (div_done) begin
               var_all_in = sat_var(div_quot);
               state_in   = ST_WIN_CHK;
            end
         end
         ST_WIN_CHK: begin
            if (count_ff > COUNT_W'(w_eff)) begin
               so_in        = sl_mean_ff;
               div_req      = '{start: 1'b1, short_op: 1'b1};
               div_dividend = DIVIDEND_W'(mag34(dw));
               div_divisor  = DIVISOR_W'(w_eff);
               state_in     = ST_DIV_WMEAN;
            end else begin
               sl_mean_in = run_mean_ff;
               sl_sq_in   = run_sq_ff;
               var_win_in = var_all_ff;
               state_in   = ST_DONE;
            end
         end
         ST_DIV_WMEAN: begin
            if (div_done) begin
               sl_mean_in = sn_clamped;
               state_in   = ST_MUL_WX;
            end
         end
         ST_ACC_WIN: begin
            sl_sq_in = apply_delta(sl_sq_ff, 42'(tx_ff) - 42'(term));
            if (w_eff > CFG_W'(1)) begin
               div_req      = '{start: 1'b1, short_op: 1'b0};
               div_dividend = sl_sq_in;
               div_divisor  = DIVISOR_W'(w_eff - CFG_W'(1));
               state_in     = ST_DIV_WVAR;
            end else begin
               var_win_in = '0;
               state_in   = ST_DONE;
            end
         end
         ST_DIV_WVAR: begin
            if (div_done) begin
               var_win_in = sat_var(div_quot);
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               o_total_in   = count_ff;
               o_mean_in    = run_mean_ff;
               o_var_in     = var_all_ff;
               o_wmean_in   = sl_mean_ff;
               o_wvar_in    = var_win_ff;
               o_min_in     = min_ff;
               o_max_in     = max_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wl_ff        <= WINDOW_RESET;
         count_ff     <= '0;
         run_mean_ff  <= '0;
         run_sq_ff    <= '0;
         sl_mean_ff   <= '0;
         sl_sq_ff     <= '0;
         slot_ff      <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wl_ff        <= wl_in;
         count_ff     <= count_in;
         run_mean_ff  <= run_mean_in;
         run_sq_ff    <= run_sq_in;
         sl_mean_ff   <= sl_mean_in;
         sl_sq_ff     <= sl_sq_in;
         slot_ff      <= slot_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      da_ff       <= da_in;
      so_ff       <= so_in;
      prod_ff     <= prod_in;
      prod_neg_ff <= prod_neg_in;
      tx_ff       <= tx_in;
      var_all_ff  <= var_all_in;
      var_win_ff  <= var_win_in;
      o_total_ff  <= o_total_in;
      o_mean_ff   <= o_mean_in;
      o_var_ff    <= o_var_in;
      o_wmean_ff  <= o_wmean_in;
      o_wvar_ff   <= o_wvar_in;
      o_min_ff    <= o_min_in;
      o_max_ff    <= o_max_in;
   end

   // ring store: read the leaving sample, write the new one (read sees old data)
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mem[slot_ff] <= req_sample;
         leave_ff     <= mem[oldest_ext[ADDR_W-1:0]];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sample_total    = o_total_ff;
   assign rsp_mean_all        = o_mean_ff;
   assign rsp_variance_all    = o_var_ff;
   assign rsp_mean_window     = o_wmean_ff;
   assign rsp_variance_window = o_wvar_ff;
   assign rsp_smallest        = o_min_ff;
   assign rsp_largest         = o_max_ff;

endmodule

FILE: tb/sv/running_and_window_statistics_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_and_window_statistics_checker
// Watches the request, response and register channels of the statistics unit.
// It keeps its own copy of the running and window statistics, predicts every
// response and compares each one, field by field, in order.
// ----------------------------------------------------------------------------
module running_and_window_statistics_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [rws_pkg::SAMPLE_W-1:0]    req_sample,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [rws_pkg::COUNT_W-1:0]     rsp_sample_total,
   input  logic [rws_pkg::MEAN_W-1:0]      rsp_mean_all,
   input  logic [rws_pkg::VAR_W-1:0]       rsp_variance_all,
   input  logic [rws_pkg::MEAN_W-1:0]      rsp_mean_window,
   input  logic [rws_pkg::VAR_W-1:0]       rsp_variance_window,
   input  logic [rws_pkg::SAMPLE_W-1:0]    rsp_smallest,
   input  logic [rws_pkg::SAMPLE_W-1:0]    rsp_largest,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [rws_pkg::CFG_W-1:0]       csr_window_length,
   output int                              fail_count,
   output int                              stats_pending
);
   import rws_pkg::*;

   localparam longint unsigned VAR_LIMIT = 64'hFF_FFFF_FFFF;

   typedef struct {
      logic [COUNT_W-1:0]  total;
      logic [MEAN_W-1:0]   mean_all;
      logic [VAR_W-1:0]    var_all;
      logic [MEAN_W-1:0]   mean_win;
      logic [VAR_W-1:0]    var_win;
      logic [SAMPLE_W-1:0] smallest;
      logic [SAMPLE_W-1:0] largest;
   } stats_type;

   stats_type           stats_queue[$];
   logic [CFG_W-1:0]    window_len;
   int unsigned         seen_count;
   logic [MEAN_W-1:0]   all_mean;
   longint unsigned     all_sq;
   logic [MEAN_W-1:0]   win_mean;
   longint unsigned     win_sq;
   logic [SAMPLE_W-1:0] ring [WINDOW_DEPTH];
   int unsigned         ring_slot;
   logic [SAMPLE_W-1:0] low_seen;
   logic [SAMPLE_W-1:0] high_seen;

   function automatic longint deviation_term(input longint a, input longint b);
      longint unsigned ma, mb, p;
      ma = (a < 0) ? longint'(-a) : a;
      mb = (b < 0) ? longint'(-b) : b;
      p  = (ma * mb) >> 24;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint unsigned sq_update(input longint unsigned acc,
                                                  input longint d);
      longint unsigned u;
      if (d >= 0) begin
         u = d;
         return (acc > ~64'd0 - u) ? ~64'd0 : acc + u;
      end
      u = -d;
      return (acc < u) ? 64'd0 : acc - u;
   endfunction

   function automatic longint unsigned variance(input longint unsigned sq,
                                                 input int unsigned div);
      longint unsigned v;
      v = sq / longint'(div);
      return (v > VAR_LIMIT) ? VAR_LIMIT : v;
   endfunction

   function automatic void absorb_sample(input logic [SAMPLE_W-1:0] s);
      stats_type       e;
      int unsigned     w, oldest;
      logic [SAMPLE_W-1:0] leaving;
      longint          x, f, om, nm, so, sn;
      longint unsigned var_all;
      x = longint'(s) * 65536;
      w = (window_len == 0) ? 1 : (window_len > WINDOW_DEPTH) ? WINDOW_DEPTH : window_len;
      oldest = (ring_slot + WINDOW_DEPTH - w) % WINDOW_DEPTH;
      leaving = ring[oldest];
      ring[ring_slot] = s;
      ring_slot = (ring_slot + 1) % WINDOW_DEPTH;
      if (seen_count < COUNT_MAX) seen_count++;

      om = longint'(all_mean);
      nm = om + (x - om) / longint'(seen_count);
      all_mean = nm[31:0];
      all_sq = sq_update(all_sq, deviation_term(x - om, x - nm));
      var_all = (seen_count > 1) ? variance(all_sq, seen_count - 1) : 0;

      if (seen_count > w) begin
         f  = longint'(leaving) * 65536;
         so = longint'(win_mean);
         sn = so + (x - f) / longint'(w);
         if (sn < 0) sn = 0;
         if (sn > longint'(MEAN_MAX)) sn = longint'(MEAN_MAX);
         win_mean = sn[31:0];
         win_sq = sq_update(win_sq,
                            deviation_term(x - so, x - sn) - deviation_term(f - so, f - sn));
         e.var_win = (w > 1) ? VAR_W'(variance(win_sq, w - 1)) : '0;
      end else begin
         win_mean = all_mean;
         win_sq = all_sq;
         e.var_win = VAR_W'(var_all);
      end
      if (s > high_seen) high_seen = s;
      if (s < low_seen) low_seen = s;

      e.total    = seen_count[COUNT_W-1:0];
      e.mean_all = all_mean;
      e.var_all  = VAR_W'(var_all);
      e.mean_win = win_mean;
      e.smallest = low_seen;
      e.largest  = high_seen;
      stats_queue.push_back(e);
   endfunction

   function automatic void check_field(input string name, input logic [63:0] exp_v,
                                       input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s expected %0h actual %0h", name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      stats_type e;
      if (reset) begin
         stats_queue.delete();
         fail_count = 0;
         window_len <= WINDOW_RESET;
         seen_count = 0;
         all_mean = '0;
         all_sq = 0;
         win_mean = '0;
         win_sq = 0;
         ring_slot = 0;
         low_seen = '1;
         high_seen = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (stats_queue.size() == 0) begin
               $error("response transaction with no request outstanding");
               fail_count++;
            end else begin
               e = stats_queue.pop_front();
               check_field("sample_total", 64'(e.total), 64'(rsp_sample_total));
               check_field("mean_all", 64'(e.mean_all), 64'(rsp_mean_all));
               check_field("variance_all", 64'(e.var_all), 64'(rsp_variance_all));
               check_field("mean_window", 64'(e.mean_win), 64'(rsp_mean_window));
               check_field("variance_window", 64'(e.var_win), 64'(rsp_variance_window));
               check_field("smallest", 64'(e.smallest), 64'(rsp_smallest));
               check_field("largest", 64'(e.largest), 64'(rsp_largest));
            end
         end
         if (req_valid && !req_stall)
            absorb_sample(req_sample);
         if (csr_valid && csr_ready)
            window_len <= csr_window_length;
      end
      stats_pending = stats_queue.size();
   end

endmodule

FILE: tb/sv/running_and_window_statistics_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_and_window_statistics_unit_tb
// Drives samples and window lengths into the statistics unit with random gaps
// and backpressure (not at length 200); the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module running_and_window_statistics_unit_tb;
   import rws_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 300;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [COUNT_W-1:0]  rsp_sample_total;
   logic [MEAN_W-1:0]   rsp_mean_all;
   logic [VAR_W-1:0]    rsp_variance_all;
   logic [MEAN_W-1:0]   rsp_mean_window;
   logic [VAR_W-1:0]    rsp_variance_window;
   logic [SAMPLE_W-1:0] rsp_smallest;
   logic [SAMPLE_W-1:0] rsp_largest;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CFG_W-1:0]    csr_window_length = '0;
   int                  fail_count;
   int                  stats_pending;
   logic                no_gaps = 1'b0;
   int                  quiet_cycles = 0;

   always #1 clock = ~clock;

   running_and_window_statistics_unit DUT (.*);

   running_and_window_statistics_checker checker_inst (.*);

   always @(negedge clock)
      rsp_stall <= no_gaps ? 1'b0 : ($urandom_range(99) < 35);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // entered and left at a falling edge
   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      if (!no_gaps)
         while ($urandom_range(99) < 35) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic set_window(input logic [CFG_W-1:0] len);
      req_valid <= 1'b0;
      wait (stats_pending == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_window_length <= len;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample(input logic [SAMPLE_W-1:0] center);
      int pick;
      pick = $urandom_range(99);
      if (pick < 30) return SAMPLE_W'($urandom);
      if (pick < 60) return SAMPLE_W'(center + $urandom_range(15) - 8);
      if (pick < 80) return $urandom_range(1) ? '1 : '0;
      return SAMPLE_W'($urandom_range(255));
   endfunction

   initial begin
      logic [CFG_W-1:0]    lengths [10] = '{11'd1, 11'd2, 11'd0, 11'd3, 11'd7, 11'd64,
                                            11'd200, 11'd2047, 11'd1025, 11'd5};
      int                  counts  [10] = '{60, 60, 50, 60, 60, 60, 100, 120, 150, 60};
      logic [SAMPLE_W-1:0] center;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes with the reset window length
      send_sample(16'h0000);
      send_sample(16'hFFFF);
      send_sample(16'hFFFF);
      send_sample(16'h0000);
      send_sample(16'h5555);
      send_sample(16'hAAAA);
      send_sample(16'h0001);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'h0000);
      send_sample(16'h0000);
      send_sample(16'hFFFE);
      for (int i = 0; i < 6; i++) send_sample(16'd1000);

      for (int p = 0; p < 10; p++) begin
         set_window(lengths[p]);
         no_gaps = (p == 6);
         center = SAMPLE_W'($urandom);
         for (int i = 0; i < counts[p]; i++) begin
            if ($urandom_range(49) == 0) center = SAMPLE_W'($urandom);
            send_sample(random_sample(center));
         end
      end
      no_gaps = 1'b0;
      req_valid <= 1'b0;

      wait (stats_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
